/* hdl/ghpmd_pkg.sv */
// ----------------------------------------------------------------------------
// ghpmd_pkg: shared definitions for the gravity high-pass motion detector
// Register indexes, reset values and fixed output constants.
// ----------------------------------------------------------------------------
package ghpmd_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FILTER_ALPHA      = 3'd0;
  localparam cfg_idx_t CFG_LINEAR_THRESHOLD  = 3'd1;
  localparam cfg_idx_t CFG_ANGULAR_THRESHOLD = 3'd2;
  localparam cfg_idx_t CFG_REFRACTORY_MS     = 3'd3;
  localparam cfg_idx_t CFG_KINETIC_LIMIT     = 3'd4;

  localparam logic [15:0] RST_FILTER_ALPHA      = 16'd3932;
  localparam logic [15:0] RST_LINEAR_THRESHOLD  = 16'd179;
  localparam logic [15:0] RST_ANGULAR_THRESHOLD = 16'd768;
  localparam logic [15:0] RST_REFRACTORY_MS     = 16'd350;
  localparam logic [10:0] RST_KINETIC_LIMIT     = 11'd384;

  // Largest kinetic magnitude and the Q8.8 value of 1.0
  localparam logic [10:0] KIN_MAX   = 11'd1024;
  localparam logic [15:0] SCORE_ONE = 16'd256;

endpackage

/* hdl/gravity_highpass_motion_detector.sv */
// ----------------------------------------------------------------------------
// gravity_highpass_motion_detector: IMU motion scoring with gravity removal
// Sequencer around one shift-add multiplier, one bit-serial square root and
// one bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Flow: an accepted sample runs through the serial multiplier (nine products),
//   the two roots and the four quotients before output valid; in_ready_o is
//   low from input accept until the result is loaded into the output register.
// Reset: clears filter and event state, loads register defaults; ready at once.
module gravity_highpass_motion_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_z_i,
  input  logic signed [SAMPLE_BITS-1:0] rate_x_i,
  input  logic signed [SAMPLE_BITS-1:0] rate_y_i,
  input  logic signed [SAMPLE_BITS-1:0] rate_z_i,
  input  logic        [TIME_BITS-1:0]   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic        [15:0]            motion_score_o,
  output logic signed [11:0]            motion_x_o,
  output logic signed [11:0]            motion_y_o,
  output logic        [15:0]            rate_magnitude_o,
  output logic                          motion_event_o,
  output logic        [31:0]            event_total_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  ghpmd_pkg::cfg_idx_t           cfg_index_i,
  input  logic        [15:0]            cfg_data_i
);

  localparam int S    = SAMPLE_BITS;
  localparam int GW   = S + 17;                 // gravity estimate, Q.16 scaled
  localparam int DFW  = S + 18;                 // sample minus gravity
  localparam int MAGW = S + 6;                  // linear component magnitude
  localparam int LW   = S + 6;                  // signed linear component
  localparam int MPW  = (MAGW > 16) ? MAGW : 16; // multiplier operand / steps
  localparam int PW   = (DFW + 16 > 2 * MPW + 1) ? DFW + 16 : 2 * MPW + 1;
  localparam int QW   = 2 * MAGW;               // sum of squares
  localparam int RW   = MAGW;                   // root width
  localparam int DW   = S + 10;                 // dividend / quotient width
  localparam int CW   = $clog2(((DW > MPW) ? DW : MPW) + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FSET, ST_MUL, ST_FUPD, ST_SSET, ST_SACC,
    ST_RSET, ST_ROOT, ST_DSET, ST_DIV, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [15:0] alpha_q, lin_thr_q, ang_thr_q, refr_q;
  logic [10:0] kin_lim_q;

  // Captured sample
  logic signed [S-1:0]   smp_a_q [3];
  logic signed [S-1:0]   smp_r_q [3];
  logic [TIME_BITS-1:0]  now_q;

  // Filter and event state
  logic signed [GW-1:0]  grav_q [3];
  logic                  gvalid_q;
  logic [TIME_BITS-1:0]  last_q;
  logic [31:0]           evcnt_q;

  // Datapath
  logic signed [LW-1:0]  lin_q [3];
  logic signed [PW-1:0]  mc_q, acc_q;
  logic [MPW-1:0]        mp_q;
  logic [CW-1:0]         cnt_q;
  logic [2:0]            idx_q;
  logic                  sq_q;
  logic [QW-1:0]         sum_lin_q, sum_rate_q, rad_q;
  logic [RW+1:0]         rem_q;
  logic [RW-1:0]         root_q, lin_len_q, rate_len_q;
  logic [DW-1:0]         dnum_q, quo_q;
  logic [DW-1:0]         quot_q [4];
  logic [15:0]           drem_q, den_q;

  // Output register
  logic                  out_valid_q;
  logic [15:0]           score_q, rmag_q;
  logic signed [11:0]    kx_q, ky_q;
  logic                  event_q;
  logic [31:0]           total_q;

  // Filter datapath
  logic signed [S-1:0]   a_sel;
  logic signed [GW-1:0]  g_sel, scaled, g_cur, g_new;
  logic signed [DFW-1:0] diff;
  logic signed [LW-1:0]  lin_new;

  // Shared multiplier step
  logic signed [PW-1:0]  acc_nx;

  // Squares
  logic signed [LW-1:0]  sq_s;
  logic [MAGW-1:0]       sq_mag, mag_x, mag_y;

  // Root step
  logic [RW+1:0]         rem2, trial;
  logic                  root_ge;

  // Divide step
  logic [16:0]           r2;
  logic                  div_ge;
  logic [DW-1:0]         numer, quo_nx;

  // Result assembly
  logic [DW-1:0]         score_full;
  logic [15:0]           score_sat, rmag_sat;
  logic [10:0]           lim, kmag_x, kmag_y;
  logic signed [11:0]    kin_x, kin_y;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    unique case (idx_q[1:0])
      2'd1: begin
        a_sel = smp_a_q[1];
        g_sel = grav_q[1];
      end
      2'd2: begin
        a_sel = smp_a_q[2];
        g_sel = grav_q[2];
      end
      default: begin
        a_sel = smp_a_q[0];
        g_sel = grav_q[0];
      end
    endcase

    // Sample in Q.16 gravity units; the first sample loads the filter
    scaled  = GW'(a_sel) <<< 16;
    g_cur   = gvalid_q ? g_sel : scaled;
    diff    = DFW'(scaled) - DFW'(g_cur);
    g_new   = g_sel + GW'(acc_q >>> 16);
    lin_new = LW'((DFW'(scaled) - DFW'(g_new)) >>> 12);

    acc_nx = acc_q + (mp_q[0] ? mc_q : PW'(0));

    unique case (idx_q)
      3'd0:    sq_s = lin_q[0];
      3'd1:    sq_s = lin_q[1];
      3'd2:    sq_s = lin_q[2];
      3'd3:    sq_s = LW'(smp_r_q[0]);
      3'd4:    sq_s = LW'(smp_r_q[1]);
      3'd5:    sq_s = LW'(smp_r_q[2]);
      default: sq_s = '0;
    endcase
    sq_mag = sq_s[LW-1] ? MAGW'(-sq_s) : MAGW'(sq_s);
    mag_x  = lin_q[0][LW-1] ? MAGW'(-lin_q[0]) : MAGW'(lin_q[0]);
    mag_y  = lin_q[1][LW-1] ? MAGW'(-lin_q[1]) : MAGW'(lin_q[1]);

    rem2    = {rem_q[RW-1:0], rad_q[QW-1 -: 2]};
    trial   = {root_q, 2'b01};
    root_ge = (rem2 >= trial);

    r2     = {drem_q, dnum_q[DW-1]};
    div_ge = (r2 >= {1'b0, den_q});
    quo_nx = {quo_q[DW-2:0], div_ge};

    unique case (idx_q[1:0])
      2'd0:    numer = DW'({lin_len_q, 4'b0});
      2'd1:    numer = DW'({rate_len_q[S:0], 8'b0});
      2'd2:    numer = DW'({mag_y, 4'b0});
      default: numer = DW'({mag_x, 4'b0});
    endcase

    // Larger ratio, saturated to Q8.8
    score_full = (quot_q[0] > quot_q[1]) ? quot_q[0] : quot_q[1];
    score_sat  = (score_full > DW'(16'hFFFF)) ? 16'hFFFF : score_full[15:0];
    rmag_sat   = (32'(rate_len_q) > 32'h0000_FFFF) ? 16'hFFFF : 16'(rate_len_q);

    // Clamp kinetics; a zero component gives zero even without a threshold
    lim    = (kin_lim_q > ghpmd_pkg::KIN_MAX) ? ghpmd_pkg::KIN_MAX : kin_lim_q;
    kmag_x = (lin_q[1] == '0) ? 11'd0 :
             ((quot_q[2] > DW'(lim)) ? lim : quot_q[2][10:0]);
    kmag_y = (lin_q[0] == '0) ? 11'd0 :
             ((quot_q[3] > DW'(lim)) ? lim : quot_q[3][10:0]);
    kin_x  = lin_q[1][LW-1] ? -$signed({1'b0, kmag_x}) : $signed({1'b0, kmag_x});
    kin_y  = lin_q[0][LW-1] ? $signed({1'b0, kmag_y}) : -$signed({1'b0, kmag_y});

    elapsed = now_q - last_q;
    fire    = (score_full >= DW'(ghpmd_pkg::SCORE_ONE)) &&
              (elapsed >= TIME_BITS'(refr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= ghpmd_pkg::RST_FILTER_ALPHA;
      lin_thr_q   <= ghpmd_pkg::RST_LINEAR_THRESHOLD;
      ang_thr_q   <= ghpmd_pkg::RST_ANGULAR_THRESHOLD;
      refr_q      <= ghpmd_pkg::RST_REFRACTORY_MS;
      kin_lim_q   <= ghpmd_pkg::RST_KINETIC_LIMIT;
      for (int i = 0; i < 3; i++) begin
        smp_a_q[i] <= '0;
        smp_r_q[i] <= '0;
        grav_q[i]  <= '0;
        lin_q[i]   <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        quot_q[i] <= '0;
      end
      now_q       <= '0;
      gvalid_q    <= 1'b0;
      last_q      <= '0;
      evcnt_q     <= '0;
      mc_q        <= '0;
      acc_q       <= '0;
      mp_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      sq_q        <= 1'b0;
      sum_lin_q   <= '0;
      sum_rate_q  <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      lin_len_q   <= '0;
      rate_len_q  <= '0;
      dnum_q      <= '0;
      quo_q       <= '0;
      drem_q      <= '0;
      den_q       <= '0;
      out_valid_q <= 1'b0;
      score_q     <= '0;
      rmag_q      <= '0;
      kx_q        <= '0;
      ky_q        <= '0;
      event_q     <= 1'b0;
      total_q     <= '0;
    end else begin
      // Configuration writes; indexes past the list are dropped
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ghpmd_pkg::CFG_FILTER_ALPHA:      alpha_q   <= cfg_data_i;
          ghpmd_pkg::CFG_LINEAR_THRESHOLD:  lin_thr_q <= cfg_data_i;
          ghpmd_pkg::CFG_ANGULAR_THRESHOLD: ang_thr_q <= cfg_data_i;
          ghpmd_pkg::CFG_REFRACTORY_MS:     refr_q    <= cfg_data_i;
          ghpmd_pkg::CFG_KINETIC_LIMIT:     kin_lim_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      // Retire the output transaction; the final state reloads it itself
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            smp_a_q[0] <= accel_x_i;
            smp_a_q[1] <= accel_y_i;
            smp_a_q[2] <= accel_z_i;
            smp_r_q[0] <= rate_x_i;
            smp_r_q[1] <= rate_y_i;
            smp_r_q[2] <= rate_z_i;
            now_q      <= now_ms_i;
            sum_lin_q  <= '0;
            sum_rate_q <= '0;
            idx_q      <= '0;
            sq_q       <= 1'b0;
            state_q    <= ST_FSET;
          end
        end

        // Gravity filter, one axis per pass
        ST_FSET: begin
          grav_q[idx_q[1:0]] <= g_cur;
          mc_q    <= PW'(diff);
          mp_q    <= MPW'(alpha_q);
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end

        // Shift-add multiply, one multiplier bit per cycle
        ST_MUL: begin
          acc_q <= acc_nx;
          mc_q  <= mc_q <<< 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MPW - 1)) begin
            state_q <= sq_q ? ST_SACC : ST_FUPD;
          end
        end

        ST_FUPD: begin
          grav_q[idx_q[1:0]] <= g_new;
          lin_q[idx_q[1:0]]  <= lin_new;
          if (idx_q == 3'd2) begin
            gvalid_q <= 1'b1;
            idx_q    <= '0;
            sq_q     <= 1'b1;
            state_q  <= ST_SSET;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= ST_FSET;
          end
        end

        // Squares: three linear components, then three rates
        ST_SSET: begin
          mc_q    <= PW'(sq_mag);
          mp_q    <= MPW'(sq_mag);
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end

        ST_SACC: begin
          if (idx_q < 3'd3) begin
            sum_lin_q <= sum_lin_q + QW'(acc_q);
          end else begin
            sum_rate_q <= sum_rate_q + QW'(acc_q);
          end
          if (idx_q == 3'd5) begin
            idx_q   <= '0;
            state_q <= ST_RSET;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= ST_SSET;
          end
        end

        // Square root, two radicand bits per cycle
        ST_RSET: begin
          rad_q   <= (idx_q == 3'd0) ? sum_lin_q : sum_rate_q;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= '0;
          state_q <= ST_ROOT;
        end

        ST_ROOT: begin
          rem_q  <= root_ge ? rem2 - trial : rem2;
          root_q <= {root_q[RW-2:0], root_ge};
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(RW - 1)) begin
            if (idx_q == 3'd0) begin
              lin_len_q <= {root_q[RW-2:0], root_ge};
              idx_q     <= 3'd1;
              state_q   <= ST_RSET;
            end else begin
              rate_len_q <= {root_q[RW-2:0], root_ge};
              idx_q      <= '0;
              state_q    <= ST_DSET;
            end
          end
        end

        // Quotients: linear score, angular score, kinetic x, kinetic y
        ST_DSET: begin
          dnum_q  <= numer;
          den_q   <= (idx_q == 3'd1) ? ang_thr_q : lin_thr_q;
          drem_q  <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end

        ST_DIV: begin
          drem_q <= div_ge ? 16'(r2 - {1'b0, den_q}) : r2[15:0];
          quo_q  <= quo_nx;
          dnum_q <= dnum_q << 1;
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(DW - 1)) begin
            quot_q[idx_q[1:0]] <= quo_nx;
            if (idx_q == 3'd3) begin
              state_q <= ST_FIN;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= ST_DSET;
            end
          end
        end

        // Load the output register once the previous result is taken
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            score_q     <= score_sat;
            rmag_q      <= rmag_sat;
            kx_q        <= kin_x;
            ky_q        <= kin_y;
            event_q     <= fire;
            total_q     <= fire ? evcnt_q + 32'd1 : evcnt_q;
            if (fire) begin
              last_q  <= now_q;
              evcnt_q <= evcnt_q + 32'd1;
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motion_score_o   = score_q;
  assign motion_x_o       = kx_q;
  assign motion_y_o       = ky_q;
  assign rate_magnitude_o = rmag_q;
  assign motion_event_o   = event_q;
  assign event_total_o    = total_q;

endmodule

/* hdl/ghpmd_checker.sv */
// ----------------------------------------------------------------------------
// ghpmd_checker: port-level assertions for the motion detector
// Watches the result channel and its value ranges.
// ----------------------------------------------------------------------------
module ghpmd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [15:0] motion_score_o,
  input logic signed [11:0] motion_x_o,
  input logic signed [11:0] motion_y_o,
  input logic        [15:0] rate_magnitude_o,
  input logic               motion_event_o,
  input logic        [31:0] event_total_o
);

  // Hold a stalled result: score, rate magnitude and event total
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motion_score_o) &&
      $stable(rate_magnitude_o) && $stable(event_total_o))
    else $error("stalled result changed");

  a_event_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_event_o |-> motion_score_o >= ghpmd_pkg::SCORE_ONE)
    else $error("event without score of one");

  a_mx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> motion_x_o <= 12'sd1024 && motion_x_o >= -12'sd1024)
    else $error("motion_x out of range");

  a_my_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> motion_y_o <= 12'sd1024 && motion_y_o >= -12'sd1024)
    else $error("motion_y out of range");

endmodule

bind gravity_highpass_motion_detector ghpmd_checker u_ghpmd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .motion_score_o   (motion_score_o),
  .motion_x_o       (motion_x_o),
  .motion_y_o       (motion_y_o),
  .rate_magnitude_o (rate_magnitude_o),
  .motion_event_o   (motion_event_o),
  .event_total_o    (event_total_o)
);
